### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TGP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TGP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TGP_ASSERT(lbl, clk, rst_n, prop, msg)

`define TGP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/tgp_pkg.sv
package tgp_pkg;

    localparam int GRID_SIZE    = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int NUM_HEADINGS = 4;
    localparam int COORD_W      = $clog2(GRID_SIZE);
    localparam int COUNT_W      = $clog2(MAX_RESULTS);

    typedef logic [COORD_W-1:0]   coord_t;
    typedef logic [GRID_SIZE-1:0] row_t;
    typedef logic [COUNT_W-1:0]   count_t;

    localparam coord_t EDGE_COORD = coord_t'(GRID_SIZE - 1);
    localparam count_t LAST_COUNT = count_t'(MAX_RESULTS - 1);

    typedef enum logic [2:0] {
        K_PEN_UP     = 3'd0,
        K_PEN_DOWN   = 3'd1,
        K_TURN_RIGHT = 3'd2,
        K_TURN_LEFT  = 3'd3,
        K_FORWARD    = 3'd4,
        K_CLEAR      = 3'd5,
        K_READ_ROW   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        H_EAST  = 2'd0,
        H_SOUTH = 2'd1,
        H_WEST  = 2'd2,
        H_NORTH = 2'd3
    } heading_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_ADVANCE,
        OP_TURN_RIGHT,
        OP_TURN_LEFT
    } step_op_t;

    typedef struct packed {
        coord_t   x;
        coord_t   y;
        heading_t dir;
    } pose_t;

    typedef struct packed {
        logic   clear;
        logic   rd_en;
        coord_t rd_addr;
        logic   wr_en;
        coord_t wr_addr;
        row_t   wr_data;
    } mem_req_t;

endpackage

### rtl/tgp_intf.sv
interface tgp_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] step_count;
    logic [4:0] row_select;

    modport source (output valid, output kind, output step_count, output row_select,
                    input ready);
    modport sink   (input valid, input kind, input step_count, input row_select,
                    output ready);
endinterface

interface tgp_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [1:0]  heading;
    logic        pen_down;
    logic [31:0] row_bits;
    logic        last;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output pen_down, output row_bits, output last, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input pen_down, input row_bits, input last, output ready);
endinterface

### rtl/tgp_step_unit.sv
module tgp_step_unit (
    input  tgp_pkg::pose_t    pose,
    input  tgp_pkg::step_op_t op,
    output tgp_pkg::pose_t    pose_next,
    output logic              blocked
);
    import tgp_pkg::*;

    always_comb
    begin
        pose_next = pose;
        blocked   = 1'b0;
        unique case (op)
            OP_ADVANCE:
            begin
                unique case (pose.dir)
                    H_EAST:
                    begin
                        blocked     = (pose.x == EDGE_COORD);
                        pose_next.x = pose.x + coord_t'(1);
                    end
                    H_SOUTH:
                    begin
                        blocked     = (pose.y == EDGE_COORD);
                        pose_next.y = pose.y + coord_t'(1);
                    end
                    H_WEST:
                    begin
                        blocked     = (pose.x == '0);
                        pose_next.x = pose.x - coord_t'(1);
                    end
                    H_NORTH:
                    begin
                        blocked     = (pose.y == '0);
                        pose_next.y = pose.y - coord_t'(1);
                    end
                    default:
                    begin
                        blocked = 1'b1;
                    end
                endcase
            end
            OP_TURN_RIGHT:
            begin
                pose_next.dir = heading_t'(2'(pose.dir + 2'd1));
            end
            OP_TURN_LEFT:
            begin
                pose_next.dir = heading_t'(2'(pose.dir + 2'(NUM_HEADINGS - 1)));
            end
            default:
            begin
                pose_next = pose;
            end
        endcase
    end

endmodule

### rtl/tgp_grid_mem.sv
module tgp_grid_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  tgp_pkg::mem_req_t req,
    output tgp_pkg::row_t     rd_row
);
    import tgp_pkg::*;

    row_t                 mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] row_valid_reg;
    logic [GRID_SIZE-1:0] row_valid_next;
    row_t                 rd_data_reg;
    logic                 rd_valid_reg;

    // A row that was never written since the last clear reads as all zero.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (req.clear)
        begin
            row_valid_next = '0;
        end
        else if (req.wr_en)
        begin
            row_valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/turtle_grid_plotter.sv
// Channel  Dir  Beat payload
// cmd      in   kind, step_count, row_select
// res      out  pos_x, pos_y, heading, pen_down, row_bits, last
//
// Pen, turn and clear commands go straight to the emit step; read row first reads its row.
// Forward does a row read, then the mark and the result, for each visited cell (at most 32).
// Reset clears position, heading, pen and the per-row valid bits; the grid needs no sweep.
// A stalled result holds the sequencer in its emit step; cmd.ready is high only when idle.
`include "assert_macros.svh"

module turtle_grid_plotter (
    input  logic      clk,
    input  logic      rst_n,
    tgp_cmd_if.sink   cmd,
    tgp_res_if.source res
);
    import tgp_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] steps_reg, steps_next;
    coord_t     row_reg, row_next;
    logic       row_ok_reg, row_ok_next;
    pose_t      pose_reg, pose_next;
    logic       pen_reg, pen_next;
    count_t     cnt_reg, cnt_next;

    logic        res_valid_reg, res_valid_next;
    logic [4:0]  pos_x_reg, pos_y_reg;
    logic [1:0]  heading_reg;
    logic        pen_down_reg;
    logic [31:0] row_bits_reg;
    logic        last_reg;

    step_op_t step_op;
    pose_t    step_pose;
    logic     step_blocked;
    mem_req_t mem_req;
    row_t     rd_row;

    logic cmd_accept;
    logic slot_free;
    logic res_load;
    logic fwd_active;
    logic last_now;
    logic [31:0] bits_now;

    tgp_step_unit u_step (
        .pose      (pose_reg),
        .op        (step_op),
        .pose_next (step_pose),
        .blocked   (step_blocked)
    );

    tgp_grid_mem u_grid (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rd_row (rd_row)
    );

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign slot_free  = !res_valid_reg || res.ready;

    assign fwd_active = (kind_reg == K_FORWARD) && (steps_reg != 8'd0);
    assign last_now   = !fwd_active
                        || ((9'(cnt_reg) + 9'd1) >= 9'(steps_reg))
                        || (cnt_reg == LAST_COUNT)
                        || step_blocked;
    assign bits_now   = ((kind_reg == K_READ_ROW) && row_ok_reg) ? 32'(rd_row) : '0;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        steps_next  = steps_reg;
        row_next    = row_reg;
        row_ok_next = row_ok_reg;
        pose_next   = pose_reg;
        pen_next    = pen_reg;
        cnt_next    = cnt_reg;
        step_op     = OP_ADVANCE;
        res_load    = 1'b0;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    kind_next   = cmd.kind;
                    steps_next  = cmd.step_count;
                    row_next    = coord_t'(cmd.row_select);
                    row_ok_next = (int'(cmd.row_select) < GRID_SIZE);
                    cnt_next    = '0;
                    state_next  = S_EMIT;
                    unique case (cmd.kind)
                        K_PEN_UP:
                        begin
                            pen_next = 1'b0;
                        end
                        K_PEN_DOWN:
                        begin
                            pen_next = 1'b1;
                        end
                        K_TURN_RIGHT:
                        begin
                            step_op   = OP_TURN_RIGHT;
                            pose_next = step_pose;
                        end
                        K_TURN_LEFT:
                        begin
                            step_op   = OP_TURN_LEFT;
                            pose_next = step_pose;
                        end
                        K_FORWARD, K_READ_ROW:
                        begin
                            state_next = S_READ;
                        end
                        K_CLEAR:
                        begin
                            mem_req.clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = (kind_reg == K_READ_ROW) ? row_reg : pose_reg.y;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_load = 1'b1;
                    if (fwd_active && pen_reg)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pose_reg.y;
                        mem_req.wr_data = rd_row | (row_t'(1) << pose_reg.x);
                    end
                    if (last_now)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Step to the next cell; its row is fetched before it is marked.
                        pose_next  = step_pose;
                        cnt_next   = cnt_reg + count_t'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pose_reg      <= '{x: '0, y: '0, dir: H_EAST};
            pen_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pose_reg      <= pose_next;
            pen_reg       <= pen_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        steps_reg  <= steps_next;
        row_reg    <= row_next;
        row_ok_reg <= row_ok_next;
        if (res_load)
        begin
            pos_x_reg    <= 5'(pose_reg.x);
            pos_y_reg    <= 5'(pose_reg.y);
            heading_reg  <= pose_reg.dir;
            pen_down_reg <= pen_reg;
            row_bits_reg <= bits_now;
            last_reg     <= last_now;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.pos_x    = pos_x_reg;
    assign res.pos_y    = pos_y_reg;
    assign res.heading  = heading_reg;
    assign res.pen_down = pen_down_reg;
    assign res.row_bits = row_bits_reg;
    assign res.last     = last_reg;

    `TGP_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd_accept, state_reg != S_IDLE, "accepted command left the sequencer idle")
    `TGP_ASSERT_NEXT(a_more_cells, clk, rst_n, res_load && !last_now, state_reg == S_READ, "non-final forward result did not fetch the next row")
    `TGP_ASSERT_NEXT(a_heading_hold, clk, rst_n, state_reg != S_IDLE, $stable(pose_reg.dir), "heading changed while a command was in progress")
    `TGP_ASSERT(a_mark_pen, clk, rst_n, !mem_req.wr_en || (pen_reg && kind_reg == K_FORWARD), "grid written outside a pen-down forward")
    `TGP_ASSERT(a_load_slot, clk, rst_n, !res_load || !res_valid_reg || res.ready, "result loaded over an unaccepted beat")

endmodule

### tb/plot_checker.sv
module plot_checker (
    input  logic      clk,
    input  logic      rst_n,
    tgp_cmd_if        cmd,
    tgp_res_if        res,
    output int        fail_count,
    output int        pending_beats,
    output int        beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import tgp_pkg::*;

    typedef struct {
        coord_t   x;
        coord_t   y;
        heading_t hd;
        logic     pen;
        row_t     bits;
        logic     last;
    } plot_beat_t;

    row_t       canvas [GRID_SIZE];
    coord_t     turtle_x;
    coord_t     turtle_y;
    heading_t   facing;
    logic       pen_low;
    plot_beat_t expected_beats [$];
    int         mismatches = 0;
    int         checked = 0;

    function automatic plot_beat_t snapshot(row_t bits, logic fin);
        plot_beat_t b;
        b.x    = turtle_x;
        b.y    = turtle_y;
        b.hd   = facing;
        b.pen  = pen_low;
        b.bits = bits;
        b.last = fin;
        return b;
    endfunction

    // One cell along the heading; a move that would leave the grid is refused.
    function automatic bit advance_turtle();
        case (facing)
            H_EAST:
            begin
                if (turtle_x == EDGE_COORD) return 1'b0;
                turtle_x++;
            end
            H_SOUTH:
            begin
                if (turtle_y == EDGE_COORD) return 1'b0;
                turtle_y++;
            end
            H_WEST:
            begin
                if (turtle_x == '0) return 1'b0;
                turtle_x--;
            end
            default:
            begin
                if (turtle_y == '0) return 1'b0;
                turtle_y--;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic predict_command(logic [2:0] kind, logic [7:0] steps, logic [4:0] row);
        int   visited;
        row_t bits;
        bits    = '0;
        visited = 0;
        case (kind)
            K_PEN_UP:     pen_low = 1'b0;
            K_PEN_DOWN:   pen_low = 1'b1;
            K_TURN_RIGHT: facing = heading_t'(facing + 2'd1);
            K_TURN_LEFT:  facing = heading_t'(facing - 2'd1);
            K_FORWARD:
            begin
                while (visited < MAX_RESULTS && visited < int'(steps))
                begin
                    if (visited > 0 && !advance_turtle())
                        break;
                    if (pen_low)
                        canvas[turtle_y][turtle_x] = 1'b1;
                    expected_beats.push_back(snapshot('0, 1'b0));
                    visited++;
                end
                // A zero-length forward still reports the unchanged pose once.
                if (visited == 0)
                    expected_beats.push_back(snapshot('0, 1'b1));
                else
                    expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
            K_CLEAR:
            begin
                foreach (canvas[r])
                    canvas[r] = '0;
            end
            K_READ_ROW:
            begin
                if (int'(row) < GRID_SIZE)
                    bits = canvas[row];
            end
            default:
            begin
            end
        endcase
        if (kind != K_FORWARD)
            expected_beats.push_back(snapshot(bits, 1'b1));
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        plot_beat_t want;
        if (!rst_n)
        begin
            foreach (canvas[r])
                canvas[r] = '0;
            turtle_x = '0;
            turtle_y = '0;
            facing   = H_EAST;
            pen_low  = 1'b0;
            expected_beats.delete();
        end
        else
        begin
            // New expectations go in first, so a result in the same cycle is
            // still matched against the oldest one.
            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
                predict_command(cmd.kind, cmd.step_count, cmd.row_select);
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat arrived with no command waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("pos_x", 32'(want.x), 32'(res.pos_x));
                    compare_field("pos_y", 32'(want.y), 32'(res.pos_y));
                    compare_field("heading", 32'(want.hd), 32'(res.heading));
                    compare_field("pen_down", 32'(want.pen), 32'(res.pen_down));
                    compare_field("row_bits", 32'(want.bits), res.row_bits);
                    compare_field("last", 32'(want.last), 32'(res.last));
                    checked++;
                end
            end
        end
        pending_beats <= expected_beats.size();
        fail_count    <= mismatches;
        beats_checked <= checked;
    end

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tgp_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         RANDOM_ITEMS = 160;
    localparam int         MAX_IDLE     = 9;
    localparam logic [2:0] K_UNUSED     = 3'd7;

    logic clk;
    logic rst_n;
    bit   idling_on = 1'b1;
    int   cycles = 0;
    int   commands_sent = 0;
    int   fail_count;
    int   pending_beats;
    int   beats_checked;

    tgp_cmd_if cmd_if ();
    tgp_res_if res_if ();

    turtle_grid_plotter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    plot_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_if),
        .res           (res_if),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .beats_checked (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure before each beat.
    initial
    begin
        int stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idling_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (res_if.valid !== 1'b1);
        end
    end

    task automatic send_cmd(logic [2:0] kind, logic [7:0] steps, logic [4:0] row);
        int gap;
        gap = idling_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= kind;
        cmd_if.step_count <= steps;
        cmd_if.row_select <= row;
        do @(posedge clk); while (cmd_if.ready !== 1'b1);
        commands_sent++;
    endtask

    task automatic wait_results_done();
        do @(posedge clk); while (pending_beats != 0);
    endtask

    initial
    begin
        int         pick;
        logic [2:0] kind;
        logic [7:0] steps;
        rst_n             <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.kind       <= K_PEN_UP;
        cmd_if.step_count <= '0;
        cmd_if.row_select <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk: empty reads, zero and clipped moves, heading wrap,
        // pen-up moves over drawn cells, the unused code and a clear.
        send_cmd(K_READ_ROW, 8'd0, 5'd0);
        send_cmd(K_FORWARD, 8'd0, 5'd0);
        send_cmd(K_PEN_DOWN, 8'd0, 5'd0);
        send_cmd(K_FORWARD, 8'd1, 5'd0);
        send_cmd(K_FORWARD, 8'd255, 5'd0);
        send_cmd(K_FORWARD, 8'd4, 5'd0);
        send_cmd(K_TURN_RIGHT, 8'd0, 5'd0);
        send_cmd(K_FORWARD, 8'd10, 5'd0);
        send_cmd(K_TURN_RIGHT, 8'd0, 5'd0);
        send_cmd(K_PEN_UP, 8'd0, 5'd0);
        send_cmd(K_FORWARD, 8'd200, 5'd0);
        send_cmd(K_READ_ROW, 8'd0, 5'd0);
        send_cmd(K_TURN_LEFT, 8'd0, 5'd0);
        send_cmd(K_TURN_LEFT, 8'd0, 5'd0);
        send_cmd(K_FORWARD, 8'd8, 5'd0);
        send_cmd(K_READ_ROW, 8'd0, 5'd9);
        send_cmd(K_TURN_LEFT, 8'd0, 5'd0);
        send_cmd(K_PEN_DOWN, 8'd0, 5'd0);
        send_cmd(K_FORWARD, 8'd255, 5'd0);
        send_cmd(K_TURN_RIGHT, 8'd0, 5'd0);
        send_cmd(K_UNUSED, 8'd255, 5'd31);
        send_cmd(K_READ_ROW, 8'd0, 5'd31);
        send_cmd(K_CLEAR, 8'd0, 5'd0);
        send_cmd(K_READ_ROW, 8'd0, 5'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Alternate stretches with and without idle cycles on both sides.
            idling_on = ((i / 40) % 2) == 0;
            if (i == RANDOM_ITEMS / 2)
            begin
                cmd_if.valid <= 1'b0;
                wait_results_done();
            end
            pick  = $urandom_range(0, 99);
            steps = 8'($urandom_range(0, 255));
            if (pick < 10)
                kind = K_PEN_UP;
            else if (pick < 25)
                kind = K_PEN_DOWN;
            else if (pick < 37)
                kind = K_TURN_RIGHT;
            else if (pick < 49)
                kind = K_TURN_LEFT;
            else if (pick < 80)
            begin
                kind = K_FORWARD;
                case ($urandom_range(0, 9))
                    0:       steps = 8'd0;
                    1:       steps = 8'($urandom_range(0, 255));
                    default: steps = 8'($urandom_range(1, 40));
                endcase
            end
            else if (pick < 83)
                kind = K_CLEAR;
            else if (pick < 97)
                kind = K_READ_ROW;
            else
                kind = K_UNUSED;
            send_cmd(kind, steps, 5'($urandom_range(0, 31)));
        end

        cmd_if.valid <= 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands over every kind code, with and without idle cycles;",
                 commands_sent);
        $display("checked %0d result beats against the predicted turtle and grid.",
                 beats_checked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
